/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Word types, command and pin action codes, and step tables.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int DELAY_COUNT_WIDTH = 10;
    localparam int STEP_W            = 5;

    localparam logic [DELAY_COUNT_WIDTH-1:0] DELAY_RESET = DELAY_COUNT_WIDTH'(10);

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_SACK  = 3'd5;
    localparam logic [2:0] CMD_RACK  = 3'd6;

    localparam logic [2:0] ACT_SDA1       = 3'd0;
    localparam logic [2:0] ACT_SDA0       = 3'd1;
    localparam logic [2:0] ACT_SCL1       = 3'd2;
    localparam logic [2:0] ACT_SCL0       = 3'd3;
    localparam logic [2:0] ACT_SDA_BIT    = 3'd4;
    localparam logic [2:0] ACT_SAMPLE_BIT = 3'd5;
    localparam logic [2:0] ACT_SAMPLE_ACK = 3'd6;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } t_out_word;

    function automatic logic [STEP_W-1:0] last_step(input logic [2:0] cmd);
        logic [STEP_W-1:0] r;
        case (cmd)
            CMD_START: r = STEP_W'(3);
            CMD_STOP:  r = STEP_W'(2);
            CMD_WRITE: r = STEP_W'(23);
            CMD_READ:  r = STEP_W'(24);
            CMD_SACK:  r = STEP_W'(2);
            default:   r = STEP_W'(3);
        endcase
        return r;
    endfunction

    // phase is the position inside a three-step bit slot
    function automatic logic [2:0] step_action(input logic [2:0] cmd,
                                               input logic [STEP_W-1:0] step,
                                               input logic [1:0] phase);
        logic [2:0] r;
        r = ACT_SDA1;
        case (cmd)
            CMD_START: begin
                case (step[1:0])
                    2'd0:    r = ACT_SDA1;
                    2'd1:    r = ACT_SCL1;
                    2'd2:    r = ACT_SDA0;
                    default: r = ACT_SCL0;
                endcase
            end
            CMD_STOP: begin
                case (step[1:0])
                    2'd0:    r = ACT_SDA0;
                    2'd1:    r = ACT_SCL1;
                    default: r = ACT_SDA1;
                endcase
            end
            CMD_READ: begin
                if (step == '0) begin
                    r = ACT_SDA1;
                end else begin
                    case (phase)
                        2'd0:    r = ACT_SCL1;
                        2'd1:    r = ACT_SAMPLE_BIT;
                        default: r = ACT_SCL0;
                    endcase
                end
            end
            CMD_WRITE, CMD_SACK: begin
                case (phase)
                    2'd0:    r = ACT_SDA_BIT;
                    2'd1:    r = ACT_SCL1;
                    default: r = ACT_SCL0;
                endcase
            end
            default: begin
                case (step[1:0])
                    2'd0:    r = ACT_SDA1;
                    2'd1:    r = ACT_SCL1;
                    2'd2:    r = ACT_SAMPLE_ACK;
                    default: r = ACT_SCL0;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/i2cms_core.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Sequencer state and the one-tick step logic; result is combinational.
// ----------------------------------------------------------------------------
module i2cms_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_step,
    input  i2cms_pkg::t_in_word                   i_in_word,
    input  logic [i2cms_pkg::DELAY_COUNT_WIDTH-1:0] i_delay_ticks,
    output i2cms_pkg::t_out_word                  o_result
);

    localparam int DW = i2cms_pkg::DELAY_COUNT_WIDTH;
    localparam int SW = i2cms_pkg::STEP_W;

    logic [2:0]    r_cmd,   n_cmd;
    logic [SW-1:0] r_step,  n_step;
    logic [1:0]    r_phase, n_phase;
    logic [DW-1:0] r_hold,  n_hold;
    logic [7:0]    r_shift_out, n_shift_out;
    logic [7:0]    r_shift_in,  n_shift_in;
    logic          r_ack, n_ack;
    logic          r_scl, n_scl;
    logic          r_sda, n_sda;

    logic [DW-1:0] limit;
    logic [DW:0]   hold_inc;
    logic          done;
    logic          rej;

    always_comb begin
        limit       = (i_delay_ticks == '0) ? DW'(1) : i_delay_ticks;
        n_cmd       = r_cmd;
        n_step      = r_step;
        n_phase     = r_phase;
        n_hold      = r_hold;
        n_shift_out = r_shift_out;
        n_shift_in  = r_shift_in;
        n_ack       = r_ack;
        n_scl       = r_scl;
        n_sda       = r_sda;
        done        = 1'b0;
        rej         = 1'b0;
        hold_inc    = '0;

        if (r_cmd == i2cms_pkg::CMD_NONE) begin
            if (i_in_word.cmd >= i2cms_pkg::CMD_START && i_in_word.cmd <= i2cms_pkg::CMD_RACK) begin
                n_cmd   = i_in_word.cmd;
                n_step  = '0;
                n_phase = '0;
                n_hold  = '0;
                if (i_in_word.cmd == i2cms_pkg::CMD_WRITE) begin
                    n_shift_out = i_in_word.tx_byte;
                end else if (i_in_word.cmd == i2cms_pkg::CMD_SACK) begin
                    n_shift_out = {i_in_word.ack_out, 7'd0};
                end
            end
        end else if (i_in_word.cmd != i2cms_pkg::CMD_NONE) begin
            rej = 1'b1;
        end

        if (n_cmd != i2cms_pkg::CMD_NONE) begin
            if (n_hold == '0) begin
                case (i2cms_pkg::step_action(n_cmd, n_step, n_phase))
                    i2cms_pkg::ACT_SDA1: n_sda = 1'b1;
                    i2cms_pkg::ACT_SDA0: n_sda = 1'b0;
                    i2cms_pkg::ACT_SCL1: n_scl = 1'b1;
                    i2cms_pkg::ACT_SCL0: n_scl = 1'b0;
                    i2cms_pkg::ACT_SDA_BIT: begin
                        n_sda       = n_shift_out[7];
                        n_shift_out = {n_shift_out[6:0], 1'b0};
                    end
                    i2cms_pkg::ACT_SAMPLE_BIT: n_shift_in = {n_shift_in[6:0], i_in_word.sda_in};
                    default: n_ack = i_in_word.sda_in;
                endcase
            end
            hold_inc = {1'b0, n_hold} + (DW+1)'(1);
            if (hold_inc >= {1'b0, limit}) begin
                n_hold = '0;
                if (n_step >= i2cms_pkg::last_step(n_cmd)) begin
                    n_cmd   = i2cms_pkg::CMD_NONE;
                    n_step  = '0;
                    n_phase = '0;
                    done    = 1'b1;
                end else begin
                    // read: first step is the SDA release, outside the bit slots
                    if (!(n_cmd == i2cms_pkg::CMD_READ && n_step == '0)) begin
                        n_phase = (n_phase == 2'd2) ? 2'd0 : n_phase + 2'd1;
                    end
                    n_step = n_step + SW'(1);
                end
            end else begin
                n_hold = hold_inc[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= i2cms_pkg::CMD_NONE;
            r_step      <= '0;
            r_phase     <= '0;
            r_hold      <= '0;
            r_shift_out <= '0;
            r_shift_in  <= '0;
            r_ack       <= 1'b1;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (i_step) begin
            r_cmd       <= n_cmd;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_hold      <= n_hold;
            r_shift_out <= n_shift_out;
            r_shift_in  <= n_shift_in;
            r_ack       <= n_ack;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.busy_res  = (n_cmd != i2cms_pkg::CMD_NONE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_shift_in;
        o_result.ack_seen  = n_ack;
        o_result.rejected  = rej;
    end

endmodule

/* rtl/i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// One input word is one bus timer tick; each tick yields one status word.
//
//   port group   dir  handshake           payload
//   in           in   i_in_valid/o_in_ready   t_in_word
//   out          out  o_out_valid/i_out_ready t_out_word
//   cfg          in   i_cfg_we (no wait)      delay_ticks
//
// One word per cycle while the output is not stalled; each word passes through the input
// register, then the step logic into the output register.
// Sequencer state advances only when a word moves into the output register.
// Output stall backs up through the input register to o_in_ready.
// Reset is synchronous; both bus lines come up released high.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  i2cms_pkg::t_in_word                     i_in_word,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output i2cms_pkg::t_out_word                    o_out_word,
    input  logic                                    i_cfg_we,
    input  logic [i2cms_pkg::DELAY_COUNT_WIDTH-1:0] i_cfg_data
);

    logic                                    r_in_valid;
    i2cms_pkg::t_in_word                     r_in_word;
    logic                                    r_out_valid;
    i2cms_pkg::t_out_word                    r_out_word;
    logic [i2cms_pkg::DELAY_COUNT_WIDTH-1:0] r_delay;
    i2cms_pkg::t_out_word                    core_result;
    logic                                    out_free;
    logic                                    adv;

    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= i2cms_pkg::DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    i2cms_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv),
        .i_in_word     (r_in_word),
        .i_delay_ticks (r_delay),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_word <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* rtl/i2cms_checker.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input i2cms_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input i2cms_pkg::t_out_word o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.done_res && o_out_word.busy_res))
        else $error("done flagged while still busy");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
